[src/ppp_pkg.sv]
// shared types and constants for the pinhole point projection block
// no dependencies; used by every module under src
package ppp_pkg;

   // quotient bits produced by the long divider; covers the widened image
   localparam int QBITS = 18;
   // signed width of the rounded quotient
   localparam int QW = QBITS + 2;
   // accumulator width after the divide by four
   localparam int ACC_W = 64;
   // exact row sum width
   localparam int SUM_W = 66;
   // arithmetic shift for the divide by four of the row sum
   localparam int ACC_SHIFT = 2;
   // homogeneous one in the point format
   localparam int ONE_SHIFT = 16;

   localparam logic [31:0] IMAGE_SIZE_RESET = 32'd70780800;

   // register indexes
   localparam logic [3:0] REG_ROW0_LO   = 4'd0;
   localparam logic [3:0] REG_ROW0_HI   = 4'd1;
   localparam logic [3:0] REG_ROW1_LO   = 4'd2;
   localparam logic [3:0] REG_ROW1_HI   = 4'd3;
   localparam logic [3:0] REG_ROW2_LO   = 4'd4;
   localparam logic [3:0] REG_ROW2_HI   = 4'd5;
   localparam logic [3:0] REG_IMG_SIZE  = 4'd6;
   localparam logic [3:0] REG_MARGIN    = 4'd7;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic               in_front;
      logic               on_image;
      logic signed [15:0] pixel_col;
      logic signed [15:0] pixel_row;
   } rsp_payload_type;

   // divider result
   typedef struct packed {
      logic                 ovf;
      logic                 neg;
      logic signed [QW-1:0] quo;
   } div_out_type;

endpackage

[src/ppp_row_mac.sv]
// one matrix row times the homogeneous point, two register stages
// depends on ppp_pkg
module ppp_row_mac (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [63:0]                       coef_lo,
   input  logic [63:0]                       coef_hi,
   input  ppp_pkg::req_payload_type          point,
   output logic signed [ppp_pkg::ACC_W-1:0]  acc
);

   logic signed [63:0] prod0_ff, prod1_ff, prod2_ff;
   logic signed [63:0] prod0_in, prod1_in, prod2_in;
   logic signed [31:0] c3_ff;
   logic signed [ppp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [ppp_pkg::SUM_W-1:0] sum;
   logic signed [ppp_pkg::SUM_W-1:0] c3_term;

   // products, one multiplier per coordinate
   always_comb begin
      prod0_in = $signed(coef_lo[31:0])  * point.point_x;
      prod1_in = $signed(coef_lo[63:32]) * point.point_y;
      prod2_in = $signed(coef_hi[31:0])  * point.point_z;
   end

   // exact sum, then floor divide by four
   always_comb begin
      c3_term = ppp_pkg::SUM_W'(c3_ff) <<< ppp_pkg::ONE_SHIFT;
      sum = ppp_pkg::SUM_W'(prod0_ff) + ppp_pkg::SUM_W'(prod1_ff)
          + ppp_pkg::SUM_W'(prod2_ff) + c3_term;
      acc_in = ppp_pkg::ACC_W'(sum >>> ppp_pkg::ACC_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         c3_ff    <= $signed(coef_hi[63:32]);
         acc_ff   <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[src/ppp_divider.sv]
// pipelined restoring divider, one quotient bit per stage, half-even rounding
// depends on ppp_pkg
module ppp_divider (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [ppp_pkg::ACC_W-1:0]  num,
   input  logic signed [ppp_pkg::ACC_W-1:0]  den,
   output ppp_pkg::div_out_type              result
);

   localparam int QB = ppp_pkg::QBITS;
   localparam int AW = ppp_pkg::ACC_W;
   localparam int WW = AW + QB;

   logic [AW-1:0] rem_ff [0:QB];
   logic [AW-1:0] den_ff [0:QB];
   logic [QB-1:0] q_ff   [0:QB];
   logic          neg_ff [0:QB];
   logic          ovf_ff [0:QB];

   logic [AW-1:0] mag_in;
   logic          ovf_in;
   ppp_pkg::div_out_type result_ff, result_in;

   // entry: sign and magnitude, quotient range check
   always_comb begin
      mag_in = num[AW-1] ? AW'(-num) : AW'(num);
      ovf_in = {{QB{1'b0}}, mag_in} >= {den, {QB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= mag_in;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[AW-1];
         ovf_ff[0] <= ovf_in;
      end
   end

   // one compare and subtract per stage, msb first
   for (genvar s = 0; s < QB; s++) begin : g_step
      logic [WW-1:0] shifted;
      logic [WW-1:0] diff;
      logic          take;
      logic [QB-1:0] q_next;
      always_comb begin
         shifted = {{QB{1'b0}}, den_ff[s]} << (QB - 1 - s);
         diff    = {{QB{1'b0}}, rem_ff[s]} - shifted;
         take    = {{QB{1'b0}}, rem_ff[s]} >= shifted;
         q_next  = q_ff[s];
         q_next[QB - 1 - s] = take;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= take ? diff[AW-1:0] : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
            q_ff[s+1]   <= q_next;
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // round half to even and restore the sign
   logic [AW:0]   twice;
   logic [AW:0]   den_x;
   logic          up;
   logic [QB:0]   q_rnd;
   logic signed [ppp_pkg::QW-1:0] q_abs;

   always_comb begin
      twice = {rem_ff[QB], 1'b0};
      den_x = {1'b0, den_ff[QB]};
      up    = (twice > den_x) || ((twice == den_x) && q_ff[QB][0]);
      q_rnd = {1'b0, q_ff[QB]} + (QB+1)'(up);
      q_abs = $signed({1'b0, q_rnd});
      result_in.ovf = ovf_ff[QB];
      result_in.neg = neg_ff[QB];
      result_in.quo = neg_ff[QB] ? -q_abs : q_abs;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[src/pinhole_point_projection.sv]
// throughput one item per cycle while no held result stalls the pipeline
// most of the pipeline depth is the divider, one quotient bit per stage for column and row
// a held result stalls the whole pipeline in place; nothing is lost or repeated
// reset (synchronous, active high) clears valid bits and the registers to their defaults
// depends on ppp_pkg, ppp_row_mac, ppp_divider
module pinhole_point_projection (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ppp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ppp_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [63:0]              csr_data
);

   localparam int QB = ppp_pkg::QBITS;
   localparam int VLEN = QB + 4;
   localparam int FLEN = QB + 2;
   localparam int QW = ppp_pkg::QW;

   logic [63:0] row_ff [0:5];
   logic [31:0] size_ff;
   logic [9:0]  margin_ff;

   logic adv;
   logic [VLEN-1:0] vld_ff;
   logic [FLEN-1:0] front_ff;

   logic signed [ppp_pkg::ACC_W-1:0] acc_u, acc_v, acc_w;
   ppp_pkg::div_out_type div_col, div_row;

   logic                     rsp_valid_ff;
   ppp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // pipeline moves unless a finished item is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            row_ff[i] <= '0;
         end
         size_ff   <= ppp_pkg::IMAGE_SIZE_RESET;
         margin_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ppp_pkg::REG_ROW0_LO:  row_ff[0] <= csr_data;
            ppp_pkg::REG_ROW0_HI:  row_ff[1] <= csr_data;
            ppp_pkg::REG_ROW1_LO:  row_ff[2] <= csr_data;
            ppp_pkg::REG_ROW1_HI:  row_ff[3] <= csr_data;
            ppp_pkg::REG_ROW2_LO:  row_ff[4] <= csr_data;
            ppp_pkg::REG_ROW2_HI:  row_ff[5] <= csr_data;
            ppp_pkg::REG_IMG_SIZE: size_ff   <= csr_data[31:0];
            ppp_pkg::REG_MARGIN:   margin_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // row accumulators
   ppp_row_mac u_mac_u (
      .clock(clock), .adv(adv), .coef_lo(row_ff[0]), .coef_hi(row_ff[1]),
      .point(req_data), .acc(acc_u)
   );
   ppp_row_mac u_mac_v (
      .clock(clock), .adv(adv), .coef_lo(row_ff[2]), .coef_hi(row_ff[3]),
      .point(req_data), .acc(acc_v)
   );
   ppp_row_mac u_mac_w (
      .clock(clock), .adv(adv), .coef_lo(row_ff[4]), .coef_hi(row_ff[5]),
      .point(req_data), .acc(acc_w)
   );

   // column and row dividers
   ppp_divider u_div_col (
      .clock(clock), .adv(adv), .num(acc_u), .den(acc_w), .result(div_col)
   );
   ppp_divider u_div_row (
      .clock(clock), .adv(adv), .num(acc_v), .den(acc_w), .result(div_row)
   );

   // valid bits and the depth sign travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[VLEN-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff <= {front_ff[FLEN-2:0], (acc_w > 0)};
      end
   end

   // saturation and widened image test
   logic signed [QW-1:0] lo_bound, col_hi, row_hi;
   logic [16:0] width_m, height_m;
   logic        col_in, row_in;

   function automatic logic signed [15:0] sat16(input ppp_pkg::div_out_type d);
      logic signed [15:0] r;
      if (d.ovf) begin
         r = d.neg ? 16'sh8000 : 16'sh7fff;
      end else if (d.quo > QW'(32767)) begin
         r = 16'sh7fff;
      end else if (d.quo < -QW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = d.quo[15:0];
      end
      return r;
   endfunction

   always_comb begin
      lo_bound = -$signed({{(QW-10){1'b0}}, margin_ff});
      width_m  = {1'b0, size_ff[15:0]}  + {7'b0, margin_ff};
      height_m = {1'b0, size_ff[31:16]} + {7'b0, margin_ff};
      col_hi   = $signed({{(QW-17){1'b0}}, width_m});
      row_hi   = $signed({{(QW-17){1'b0}}, height_m});
      col_in   = !div_col.ovf && (div_col.quo >= lo_bound) && (div_col.quo < col_hi);
      row_in   = !div_row.ovf && (div_row.quo >= lo_bound) && (div_row.quo < row_hi);
      if (front_ff[FLEN-1]) begin
         rsp_data_in.in_front  = 1'b1;
         rsp_data_in.on_image  = col_in && row_in;
         rsp_data_in.pixel_col = sat16(div_col);
         rsp_data_in.pixel_row = sat16(div_row);
      end else begin
         rsp_data_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[VLEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/pinhole_point_projection_checker.sv]
// result checker for the pinhole point projection block: watches the point, result
// and register channels, predicts each projected pixel and compares. depends on ppp_pkg
`timescale 1ns / 100ps
module pinhole_point_projection_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  ppp_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ppp_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [63:0]              csr_data,
   output int                       fail_count,
   output int                       pending,
   output int                       front_count,
   output int                       on_image_count
);

   typedef logic signed [127:0] wide_type;

   // shadow copy of the projection matrix and image window
   logic [63:0] matrix_reg [0:5];
   logic [31:0] image_size_reg;
   logic [9:0]  margin_reg;

   ppp_pkg::rsp_payload_type pixel_queue [$];

   // floor((c0*x + c1*y + c2*z + c3*2^16) / 4) for one matrix row
   function automatic wide_type row_sum(input logic [63:0] lo, input logic [63:0] hi,
                                        input ppp_pkg::req_payload_type pt);
      wide_type s;
      s = wide_type'($signed(lo[31:0])) * wide_type'(pt.point_x)
        + wide_type'($signed(lo[63:32])) * wide_type'(pt.point_y)
        + wide_type'($signed(hi[31:0])) * wide_type'(pt.point_z)
        + (wide_type'($signed(hi[63:32])) <<< 16);
      return s >>> 2;
   endfunction

   // num / den rounded to nearest, ties to even; den > 0
   function automatic wide_type round_quotient(input wide_type num, input wide_type den);
      logic        neg;
      logic [127:0] a, q, r;
      neg = num < 0;
      a = neg ? -num : num;
      q = a / den;
      r = a % den;
      if (2 * r > den || (2 * r == den && q[0]))
         q = q + 1;
      return neg ? -wide_type'(q) : wide_type'(q);
   endfunction

   function automatic logic signed [15:0] clamp16(input wide_type v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic ppp_pkg::rsp_payload_type project_point(
         input ppp_pkg::req_payload_type pt);
      ppp_pkg::rsp_payload_type res;
      wide_type u, v, w, col, row, m, wd, ht;
      res = '0;
      u = row_sum(matrix_reg[0], matrix_reg[1], pt);
      v = row_sum(matrix_reg[2], matrix_reg[3], pt);
      w = row_sum(matrix_reg[4], matrix_reg[5], pt);
      if (w > 0) begin
         col = round_quotient(u, w);
         row = round_quotient(v, w);
         m = wide_type'(margin_reg);
         wd = wide_type'(image_size_reg[15:0]);
         ht = wide_type'(image_size_reg[31:16]);
         res.in_front = 1'b1;
         res.on_image = col >= -m && col < wd + m && row >= -m && row < ht + m;
         res.pixel_col = clamp16(col);
         res.pixel_row = clamp16(row);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      front_count = 0;
      on_image_count = 0;
   end

   always @(posedge clock) begin
      ppp_pkg::rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < 6; i++)
            matrix_reg[i] <= '0;
         image_size_reg <= ppp_pkg::IMAGE_SIZE_RESET;
         margin_reg <= '0;
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            if (csr_index <= ppp_pkg::REG_ROW2_HI)
               matrix_reg[csr_index[2:0]] <= csr_data;
            else if (csr_index == ppp_pkg::REG_IMG_SIZE)
               image_size_reg <= csr_data[31:0];
            else if (csr_index == ppp_pkg::REG_MARGIN)
               margin_reg <= csr_data[9:0];
         end
         // each accepted point queues its predicted pixel
         if (req_valid && !req_stall)
            pixel_queue = {pixel_queue, project_point(req_data)};
         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected result, in_front", rsp_data.in_front, -1);
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_data.in_front !== want.in_front)
                  report_mismatch("in_front", rsp_data.in_front, want.in_front);
               if (rsp_data.on_image !== want.on_image)
                  report_mismatch("on_image", rsp_data.on_image, want.on_image);
               if (rsp_data.pixel_col !== want.pixel_col)
                  report_mismatch("pixel_col", rsp_data.pixel_col, want.pixel_col);
               if (rsp_data.pixel_row !== want.pixel_row)
                  report_mismatch("pixel_row", rsp_data.pixel_row, want.pixel_row);
               front_count += want.in_front;
               on_image_count += want.on_image;
            end
         end
      end
      pending <= pixel_queue.size();
   end

endmodule

[dv/tb_pinhole_point_projection.sv]
// top of the pinhole point projection testbench: clock, reset, point stimulus,
// register phases and verdict. depends on ppp_pkg and pinhole_point_projection_checker
`timescale 1ns / 100ps
module tb_pinhole_point_projection;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 160;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   ppp_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   ppp_pkg::rsp_payload_type rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [3:0]               csr_index;
   logic [63:0]              csr_data;

   int  fail_count, pending, front_count, on_image_count;
   int  points_sent;
   int  quiet_cycles;
   bit  calm;
   bit  long_hold;

   pinhole_point_projection u_dut (.*);

   pinhole_point_projection_checker u_checker (.*);

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("pinhole_point_projection: mismatch");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold when asked
   initial begin
      rsp_stall = 1'b1;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      req_valid <= 1'b1;
      req_data  <= '{point_x: x, point_y: y, point_z: z};
      do @(posedge clock); while (req_stall);
      points_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // let the pipeline empty before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // pinhole camera: focal lengths and principal point, depth = z
   task automatic load_camera(input int fx, input int fy, input int cx, input int cy);
      write_reg(ppp_pkg::REG_ROW0_LO, {32'd0, 32'(fx <<< 16)});
      write_reg(ppp_pkg::REG_ROW0_HI, {32'd0, 32'(cx <<< 16)});
      write_reg(ppp_pkg::REG_ROW1_LO, {32'(fy <<< 16), 32'd0});
      write_reg(ppp_pkg::REG_ROW1_HI, {32'd0, 32'(cy <<< 16)});
      write_reg(ppp_pkg::REG_ROW2_LO, 64'd0);
      write_reg(ppp_pkg::REG_ROW2_HI, {32'd0, ONE_Q16});
   endtask

   task automatic load_random_matrix;
      for (int i = 0; i < 6; i++)
         write_reg(ppp_pkg::REG_ROW0_LO + 4'(i), {$urandom, $urandom});
   endtask

   // mostly points in front of a pinhole camera within the field of view, some random or behind it
   task automatic send_scene_point;
      int z, x, y;
      case ($urandom_range(0, 9))
         0: send_point($urandom, $urandom, $urandom);
         1: send_point($urandom, $urandom, -int'($urandom_range(0, 1 << 20)));
         default: begin
            z = $urandom_range(6554, 50 << 16);
            x = int'($urandom_range(0, 4 * (z >> 4))) - 2 * (z >> 4);
            y = int'($urandom_range(0, 4 * (z >> 4))) - 2 * (z >> 4);
            send_point(x <<< 3, y <<< 3, z);
         end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = ppp_pkg::REG_ROW0_LO;
      csr_data = '0;
      calm = 1'b0;
      long_hold = 1'b0;
      points_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero matrix after reset: depth zero, behind the camera
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      drain();

      // unit matrix with constant depth: pixel equals the point in Q16.16
      write_reg(ppp_pkg::REG_ROW0_LO, {32'd0, ONE_Q16});
      write_reg(ppp_pkg::REG_ROW0_HI, 64'd0);
      write_reg(ppp_pkg::REG_ROW1_LO, {ONE_Q16, 32'd0});
      write_reg(ppp_pkg::REG_ROW1_HI, 64'd0);
      write_reg(ppp_pkg::REG_ROW2_LO, 64'd0);
      write_reg(ppp_pkg::REG_ROW2_HI, {ONE_Q16, 32'd0});
      send_point(32'h0000_8000, 32'h0001_8000, 32'd0);     // ties round to even
      send_point(32'hFFFF_8000, 32'hFFFE_8000, 32'd0);
      send_point(32'h0000_8001, 32'h0000_7FFF, 32'd0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF); // saturation
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'd0, 32'd0, 32'd0);
      send_point(32'h077F_FFFF, 32'h0437_FFFF, 32'd0);     // rounds to the first pixel off image
      send_point(32'h0780_0000, 32'h0438_0000, 32'd0);     // first pixel off image
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'd0);
      drain();

      // depth from z: zero and negative depth are behind the camera
      write_reg(ppp_pkg::REG_ROW2_LO, 64'd0);
      write_reg(ppp_pkg::REG_ROW2_HI, {32'd0, ONE_Q16});
      send_point(32'h0001_0000, 32'h0001_0000, 32'd0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000);
      drain();

      // widest margin, zero-size image, unknown index ignored
      write_reg(ppp_pkg::REG_IMG_SIZE, 64'd0);
      write_reg(ppp_pkg::REG_MARGIN, 64'd1023);
      write_reg(ppp_pkg::REG_MARGIN + 4'($urandom_range(1, 8)), {$urandom, $urandom});
      send_point(32'hFC01_0000, 32'h03FE_0000, 32'h0001_0000);
      send_point(32'hFC00_0000, 32'h03FF_0000, 32'h0001_0000);
      send_point(32'd0, 32'd0, 32'h0001_0000);
      drain();
      write_reg(ppp_pkg::REG_MARGIN, 64'd0);
      send_point(32'd0, 32'd0, 32'h0001_0000);             // nothing on an empty image
      drain();

      // typical camera, default image
      write_reg(ppp_pkg::REG_IMG_SIZE, 64'(ppp_pkg::IMAGE_SIZE_RESET));
      load_camera(500, 500, 960, 540);
      repeat (260) send_scene_point();
      drain();

      // wide margin, receiver holds off so the pipeline backs up
      load_camera(800, 750, 320, 240);
      write_reg(ppp_pkg::REG_IMG_SIZE, 64'h0000_0000_01E0_0280);
      write_reg(ppp_pkg::REG_MARGIN, 64'd1023);
      long_hold = 1'b1;
      repeat (150) send_scene_point();
      drain();

      // arbitrary matrices, largest image
      write_reg(ppp_pkg::REG_IMG_SIZE, 64'hFFFF_FFFF);
      write_reg(ppp_pkg::REG_MARGIN, 64'($urandom_range(0, 1023)));
      for (int k = 0; k < 4; k++) begin
         load_random_matrix();
         repeat (35) send_point($urandom, $urandom, $urandom);
         drain();
      end

      // extreme coefficients
      for (int i = 0; i < 6; i++)
         write_reg(ppp_pkg::REG_ROW0_LO + 4'(i), (i % 2) ? 64'h7FFF_FFFF_8000_0000
                                                         : 64'h8000_0000_7FFF_FFFF);
      repeat (30) send_point($urandom, $urandom, $urandom);
      drain();
      for (int i = 0; i < 6; i++)
         write_reg(ppp_pkg::REG_ROW0_LO + 4'(i), 64'h7FFF_FFFF_7FFF_FFFF);
      repeat (30) send_point($urandom, $urandom, $urandom);
      drain();

      // closing stretch at full rate
      calm = 1'b1;
      write_reg(ppp_pkg::REG_IMG_SIZE, 64'(ppp_pkg::IMAGE_SIZE_RESET));
      write_reg(ppp_pkg::REG_MARGIN, 64'd16);
      load_camera(600, 600, 960, 540);
      repeat (60) @(posedge clock);
      repeat (90) send_scene_point();
      drain();

      $display("covered %0d points: %0d in front of the camera, %0d on the image",
               points_sent, front_count, on_image_count);
      $display("phases: reset matrix, unit and pinhole cameras, random and extreme matrices");
      if (fail_count == 0)
         $display("pinhole_point_projection: match");
      else
         $display("pinhole_point_projection: mismatch");
      $finish;
   end

endmodule
